// File: hw/rtl/wag_pkg.sv
package wag_pkg;

  // Field widths of the input and result beats
  localparam int CMD_W    = 2;
  localparam int SENS_W   = 1;
  localparam int VAL_W    = 16;
  localparam int USED_W   = 6;
  localparam int NUM_CH   = 3;
  localparam int SAMPLE_W = NUM_CH * VAL_W;

  // Sensors reachable through a one-bit sensor index
  localparam int NUM_IDX  = 2;

  // Sample counter and warm-up timing
  localparam int CNT_W     = 16;
  localparam int ELAPSED_W = 22;
  localparam int WARM_W    = 12;
  localparam int MS_PER_S  = 1000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Configuration port
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_START,
    CMD_TICK,
    CMD_SAMPLE,
    CMD_AVERAGE
  } cmd_t;

endpackage

// File: hw/rtl/wag_in_if.sv
interface wag_in_if;
  logic                        valid;
  logic                        ready;
  logic [wag_pkg::CMD_W-1:0]   command;
  logic [wag_pkg::SENS_W-1:0]  sensor_index;
  logic [wag_pkg::VAL_W-1:0]   pm1_value;
  logic [wag_pkg::VAL_W-1:0]   pm25_value;
  logic [wag_pkg::VAL_W-1:0]   pm10_value;

  modport source (
    output valid, command, sensor_index, pm1_value, pm25_value, pm10_value,
    input  ready
  );

  modport sink (
    input  valid, command, sensor_index, pm1_value, pm25_value, pm10_value,
    output ready
  );
endinterface

// File: hw/rtl/wag_out_if.sv
interface wag_out_if;
  logic                        valid;
  logic                        ready;
  logic [wag_pkg::SENS_W-1:0]  result_sensor;
  logic [wag_pkg::VAL_W-1:0]   avg_pm1;
  logic [wag_pkg::VAL_W-1:0]   avg_pm25;
  logic [wag_pkg::VAL_W-1:0]   avg_pm10;
  logic [wag_pkg::USED_W-1:0]  samples_used;
  logic                        no_samples;

  modport source (
    output valid, result_sensor, avg_pm1, avg_pm25, avg_pm10, samples_used, no_samples,
    input  ready
  );

  modport sink (
    input  valid, result_sensor, avg_pm1, avg_pm25, avg_pm10, samples_used, no_samples,
    output ready
  );
endinterface

// File: hw/rtl/wag_div.sv
// Restoring divider, one quotient bit per cycle. The dividend shifts out of
// the top of work_r while quotient bits shift in at the bottom.
module wag_div #(
  parameter int N_W = 22,
  parameter int D_W = 6,
  parameter int Q_W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [Q_W-1:0] quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] work_r, work_nxt;
  logic [D_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [D_W:0]   rem_sh;
  logic           ge;

  // Trial subtraction of one step
  assign rem_sh = {rem_r, work_r[N_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt  = ge ? D_W'(rem_sh - {1'b0, dsr_r}) : D_W'(rem_sh);
      work_nxt = {work_r[N_W-2:0], ge};
      cnt_nxt  = cnt_r + CW'(1);
      if (cnt_r == CW'(N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control flags under reset; datapath needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r[Q_W-1:0];

endmodule

// File: hw/rtl/warmup_gated_window_averager_core.sv
// Warm-up gated window averager for three-channel particulate readings.
// in_if carries commands: start, millisecond tick, sample, average request.
// out_if carries one result beat per average request and nothing otherwise.
// The APB port holds one register, warm_up_seconds; paddr is not decoded.
// Start, tick and sample beats leave the sequencer idle, so the block stays
// ready after them. Samples are written into a single-port-write, registered-
// read sample memory, SENSORS * BUF_DEPTH entries of three readings.
// An average request reads the sensor's counted entries one per cycle
// (min(count, BUF_DEPTH) entries), then passes the drain and divider-start
// states and starts three restoring dividers, which run in parallel at one
// cycle per quotient bit over a 16 + clog2(BUF_DEPTH + 1) bit dividend.
// The input is not ready until the result is loaded; with no counted samples
// the request goes straight from idle to the finish state.
// The memory port and the divider set how long an average holds the input.
// Reset clears sample counts, elapsed time and warm_up_seconds; the sample
// memory is not cleared, as every averaged entry has been written since reset.
// The result sits in an output register: a stalled receiver does not block
// start, tick or sample beats; only a finished average waits for it.
module warmup_gated_window_averager_core #(
  parameter int BUF_DEPTH = 32,
  parameter int SENSORS   = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wag_in_if.sink                       in_if,
  wag_out_if.source                    out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wag_pkg::CFG_AW-1:0]   paddr,
  input  logic [wag_pkg::CFG_DW-1:0]   pwdata,
  output logic [wag_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int DEPTH_TOT = SENSORS * BUF_DEPTH;
  localparam int AW        = (DEPTH_TOT > 1) ? $clog2(DEPTH_TOT) : 1;
  localparam int SW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int UW        = $clog2(BUF_DEPTH + 1);
  localparam int SUMW      = wag_pkg::VAL_W + UW;
  localparam int EW        = wag_pkg::ELAPSED_W;
  localparam int WW        = wag_pkg::WARM_W;
  localparam int CNTW      = wag_pkg::CNT_W;
  localparam int VW        = wag_pkg::VAL_W;
  localparam int NCH       = wag_pkg::NUM_CH;
  localparam int NIDX      = wag_pkg::NUM_IDX;
  localparam int DW        = wag_pkg::CFG_DW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [WW-1:0] warm_r;
  logic [EW-1:0] warm_ms_r;
  logic          cfg_wr;

  // Single register: byte-lane address bits are not decoded
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = DW'(warm_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r    <= '0;
      warm_ms_r <= '0;
    end else if (cfg_wr) begin
      warm_r    <= pwdata[WW-1:0];
      warm_ms_r <= EW'(pwdata[WW-1:0]) * EW'(wag_pkg::MS_PER_S);
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  logic                      in_acc;
  wag_pkg::cmd_t             cmd;
  logic                      sel;
  logic                      s_ok;
  logic [AW-1:0]             base_c;
  logic [UW-1:0]             used_c;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign cmd         = wag_pkg::cmd_t'(in_if.command);
  assign sel         = in_if.sensor_index;
  assign s_ok        = (32'(sel) < SENSORS);
  assign base_c      = sel ? AW'(BUF_DEPTH) : '0;

  // ---------------------------------------------------------------------------
  // Counts, ring slots and elapsed time
  // ---------------------------------------------------------------------------
  logic [CNTW-1:0] cnt_r  [NIDX];
  logic [CNTW-1:0] cnt_nxt[NIDX];
  logic [SW-1:0]   slot_r  [NIDX];
  logic [SW-1:0]   slot_nxt[NIDX];
  logic [EW-1:0]   elapsed_r, elapsed_nxt;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [wag_pkg::SAMPLE_W-1:0] wr_data;

  assign wr_addr = base_c + AW'(slot_r[sel]);
  assign wr_data = {in_if.pm10_value, in_if.pm25_value, in_if.pm1_value};
  assign used_c  = !s_ok ? '0 :
                   (cnt_r[sel] > CNTW'(BUF_DEPTH)) ? UW'(BUF_DEPTH) : UW'(cnt_r[sel]);

  always_comb begin
    cnt_nxt     = cnt_r;
    slot_nxt    = slot_r;
    elapsed_nxt = elapsed_r;
    wr_en       = 1'b0;
    if (in_acc) begin
      unique case (cmd)
        wag_pkg::CMD_START: begin
          for (int i = 0; i < NIDX; i++) begin
            cnt_nxt[i]  = '0;
            slot_nxt[i] = '0;
          end
          elapsed_nxt = '0;
        end
        wag_pkg::CMD_TICK: begin
          if (elapsed_r != wag_pkg::ELAPSED_MAX) elapsed_nxt = elapsed_r + EW'(1);
        end
        wag_pkg::CMD_SAMPLE: begin
          if (s_ok) begin
            wr_en = 1'b1;
            // Advance the count only past warm-up; the slot follows count mod depth
            if (elapsed_r > warm_ms_r) begin
              cnt_nxt[sel] = cnt_r[sel] + CNTW'(1);
              if (cnt_r[sel] == '1 || slot_r[sel] == SW'(BUF_DEPTH - 1)) begin
                slot_nxt[sel] = '0;
              end else begin
                slot_nxt[sel] = slot_r[sel] + SW'(1);
              end
            end
          end
        end
        wag_pkg::CMD_AVERAGE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NIDX; i++) begin
        cnt_r[i]  <= '0;
        slot_r[i] <= '0;
      end
      elapsed_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      slot_r    <= slot_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [wag_pkg::SAMPLE_W-1:0] mem [DEPTH_TOT];
  logic [wag_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                         rd_en;
  logic                         rd_vld_r;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                base_r, base_nxt;
  logic [UW-1:0]                idx_r, idx_nxt;

  assign rd_en   = (state_r == ST_SUM);
  assign rd_addr = base_r + AW'(idx_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= rd_en;
  end

  // ---------------------------------------------------------------------------
  // Dividers, one lane per channel
  // ---------------------------------------------------------------------------
  logic [SUMW-1:0] sum_r  [NCH];
  logic [SUMW-1:0] sum_nxt[NCH];
  logic [UW-1:0]   used_r, used_nxt;
  logic [VW-1:0]   quo [NCH];
  logic [NCH-1:0]  div_done;
  logic            div_start;
  logic            all_done;

  assign div_start = (state_r == ST_DSTART);
  assign all_done  = &div_done;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    wag_div #(
      .N_W (SUMW),
      .D_W (UW),
      .Q_W (VW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (sum_r[c]),
      .divisor  (used_r),
      .done     (div_done[c]),
      .quotient (quo[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Average sequencer and result register
  // ---------------------------------------------------------------------------
  logic                          sel_r, sel_nxt;
  logic                          nos_r, nos_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          res_sensor_r, res_sensor_nxt;
  logic [VW-1:0]                 avg_r  [NCH];
  logic [VW-1:0]                 avg_nxt[NCH];
  logic [wag_pkg::USED_W-1:0]    res_used_r, res_used_nxt;
  logic                          res_nos_r, res_nos_nxt;

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    nos_nxt        = nos_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r;
    res_sensor_nxt = res_sensor_r;
    avg_nxt        = avg_r;
    res_used_nxt   = res_used_r;
    res_nos_nxt    = res_nos_r;

    // Drop the result once the receiver takes the beat
    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;

    // Accumulate the entry read in the previous cycle
    if (rd_vld_r) begin
      for (int c = 0; c < NCH; c++) begin
        sum_nxt[c] = sum_r[c] + SUMW'(rd_data_r[c*VW +: VW]);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && cmd == wag_pkg::CMD_AVERAGE) begin
          sel_nxt  = sel;
          used_nxt = used_c;
          idx_nxt  = '0;
          base_nxt = base_c;
          nos_nxt  = (used_c == '0);
          for (int c = 0; c < NCH; c++) sum_nxt[c] = '0;
          state_nxt = (used_c == '0) ? ST_FIN : ST_SUM;
        end
      end
      ST_SUM: begin
        idx_nxt = idx_r + UW'(1);
        if (idx_r == used_r - UW'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (all_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Load the result register when it is free or being emptied
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          res_sensor_nxt = sel_r;
          for (int c = 0; c < NCH; c++) avg_nxt[c] = nos_r ? '0 : quo[c];
          res_used_nxt   = wag_pkg::USED_W'(used_r);
          res_nos_nxt    = nos_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_r        <= sel_nxt;
    nos_r        <= nos_nxt;
    used_r       <= used_nxt;
    idx_r        <= idx_nxt;
    base_r       <= base_nxt;
    sum_r        <= sum_nxt;
    res_sensor_r <= res_sensor_nxt;
    avg_r        <= avg_nxt;
    res_used_r   <= res_used_nxt;
    res_nos_r    <= res_nos_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.result_sensor = res_sensor_r;
  assign out_if.avg_pm1       = avg_r[0];
  assign out_if.avg_pm25      = avg_r[1];
  assign out_if.avg_pm10      = avg_r[2];
  assign out_if.samples_used  = res_used_r;
  assign out_if.no_samples    = res_nos_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done == '0) || (div_done == '1))
    else $error("divider lanes finished out of step");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat raised outside the finish state");

  a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == wag_pkg::CMD_TICK) |=> (elapsed_r >= $past(elapsed_r)))
    else $error("elapsed time went backwards on a tick");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(slot_r[0]) < BUF_DEPTH) && (32'(slot_r[1]) < BUF_DEPTH))
    else $error("ring slot beyond buffer depth");

endmodule

// File: dv/warmup_gated_window_averager_checker.sv
`timescale 1ns / 1ps

module warmup_gated_window_averager_checker #(
  parameter int BUF_DEPTH = 32,
  parameter int SENSORS   = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wag_in_if                          in_mon,
  wag_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [wag_pkg::CFG_AW-1:0] paddr,
  input  logic [wag_pkg::CFG_DW-1:0] pwdata,
  output int                         mismatches,
  output int                         outstanding
);

  localparam logic [wag_pkg::CFG_AW-1:0] WARM_UP_ADDR = '0;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [wag_pkg::VAL_W-1:0] pm1;
    logic [wag_pkg::VAL_W-1:0] pm25;
    logic [wag_pkg::VAL_W-1:0] pm10;
  } reading_t;

  typedef struct packed {
    logic [wag_pkg::SENS_W-1:0] sensor;
    logic [wag_pkg::VAL_W-1:0]  pm1;
    logic [wag_pkg::VAL_W-1:0]  pm25;
    logic [wag_pkg::VAL_W-1:0]  pm10;
    logic [wag_pkg::USED_W-1:0] used;
    logic                       none;
  } average_t;

  // Shadow copy of the block's state and register
  reading_t                      ring [SENSORS][BUF_DEPTH];
  logic [wag_pkg::CNT_W-1:0]     counts [SENSORS];
  logic [wag_pkg::ELAPSED_W-1:0] elapsed;
  logic [wag_pkg::WARM_W-1:0]    warm_up_s;
  average_t                      expected_avgs [$];
  average_t                      got;
  average_t                      want;

  // Truncated per-channel mean over the counted ring entries of one sensor
  function automatic average_t predict_average(input logic [wag_pkg::SENS_W-1:0] s);
    average_t    res;
    int          used;
    logic [31:0] sum1;
    logic [31:0] sum2;
    logic [31:0] sum3;
    res  = '0;
    used = 0;
    sum1 = '0;
    sum2 = '0;
    sum3 = '0;
    res.sensor = s;
    if (int'(s) < SENSORS) begin
      used = (int'(counts[s]) > BUF_DEPTH) ? BUF_DEPTH : int'(counts[s]);
    end
    if (used == 0) begin
      res.none = 1'b1;
      return res;
    end
    for (int i = 0; i < used; i++) begin
      sum1 += 32'(ring[s][i].pm1);
      sum2 += 32'(ring[s][i].pm25);
      sum3 += 32'(ring[s][i].pm10);
    end
    res.pm1  = wag_pkg::VAL_W'(sum1 / 32'(used));
    res.pm25 = wag_pkg::VAL_W'(sum2 / 32'(used));
    res.pm10 = wag_pkg::VAL_W'(sum3 / 32'(used));
    res.used = wag_pkg::USED_W'(used);
    return res;
  endfunction

  // Print one mismatch while under the report budget
  task automatic report(input string what, input average_t exp_b, input average_t act_b);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected sensor %0d pm1 %0d pm25 %0d pm10 %0d used %0d none %0d",
               exp_b.sensor, exp_b.pm1, exp_b.pm25, exp_b.pm10, exp_b.used, exp_b.none);
      $display("  actual   sensor %0d pm1 %0d pm25 %0d pm10 %0d used %0d none %0d",
               act_b.sensor, act_b.pm1, act_b.pm25, act_b.pm10, act_b.used, act_b.none);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SENSORS; s++) counts[s] = '0;
      elapsed   = '0;
      warm_up_s = '0;
      expected_avgs.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // Register write
      if (psel && penable && pwrite && pready && paddr == WARM_UP_ADDR) begin
        warm_up_s = pwdata[wag_pkg::WARM_W-1:0];
      end

      // Compare a result beat with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.result_sensor, out_mon.avg_pm1, out_mon.avg_pm25,
               out_mon.avg_pm10, out_mon.samples_used, out_mon.no_samples};
        if (expected_avgs.size() == 0) begin
          report("result beat with no request pending", '0, got);
        end else begin
          want = expected_avgs.pop_front();
          if (got.sensor !== want.sensor || got.pm1 !== want.pm1 ||
              got.pm25 !== want.pm25 || got.pm10 !== want.pm10 ||
              got.used !== want.used || got.none !== want.none) begin
            report("average result mismatch", want, got);
          end
        end
      end

      // Advance the shadow state on an input beat
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.command)
          wag_pkg::CMD_START: begin
            for (int s = 0; s < SENSORS; s++) counts[s] = '0;
            elapsed = '0;
          end
          wag_pkg::CMD_TICK: begin
            if (elapsed != wag_pkg::ELAPSED_MAX) elapsed = elapsed + 1'b1;
          end
          wag_pkg::CMD_SAMPLE: begin
            if (int'(in_mon.sensor_index) < SENSORS) begin
              ring[in_mon.sensor_index][int'(counts[in_mon.sensor_index]) % BUF_DEPTH] =
                {in_mon.pm1_value, in_mon.pm25_value, in_mon.pm10_value};
              // Count only once warm-up has passed
              if (int'(elapsed) > int'(warm_up_s) * wag_pkg::MS_PER_S) begin
                counts[in_mon.sensor_index] = counts[in_mon.sensor_index] + 1'b1;
              end
            end
          end
          wag_pkg::CMD_AVERAGE: begin
            expected_avgs.push_back(predict_average(in_mon.sensor_index));
          end
          default: ;
        endcase
      end
      outstanding = expected_avgs.size();
    end
  end

endmodule

// File: dv/warmup_gated_window_averager_core_tb.sv
`timescale 1ns / 1ps

module warmup_gated_window_averager_core_tb;

  localparam int BUF_DEPTH      = 32;
  localparam int SENSORS        = 2;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES     = 6;
  localparam logic [wag_pkg::CFG_AW-1:0] WARM_UP_ADDR = '0;

  // Per phase: register value, sender idle and receiver stall percentages,
  // beat budget and whether the receiver holds off for a long stretch
  localparam int PHASE_WARM  [NUM_PHASES] = '{0, 4095, 1, 3600, 0, 0};
  localparam int PHASE_SRC   [NUM_PHASES] = '{0, 67, 0, 34, 34, 0};
  localparam int PHASE_SNK   [NUM_PHASES] = '{0, 0, 67, 34, 34, 0};
  localparam int PHASE_BEATS [NUM_PHASES] = '{15, 10, 1000, 10, 15, 60};
  localparam bit PHASE_HOLD  [NUM_PHASES] = '{0, 0, 0, 0, 0, 1};

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [wag_pkg::CFG_AW-1:0] paddr;
  logic [wag_pkg::CFG_DW-1:0] pwdata;
  logic [wag_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  int                         mismatches;
  int                         outstanding;
  int                         src_idle_pct  = 0;
  int                         snk_stall_pct = 0;
  int                         hold_requests = 0;
  int                         hold_seen     = 0;
  int                         hold_left     = 0;
  int                         beats_sent    = 0;
  int                         idle_cycles   = 0;
  int                         phase_end;
  logic [wag_pkg::WARM_W-1:0] warm_now = '0;

  wag_in_if  in_bus ();
  wag_out_if out_bus ();

  warmup_gated_window_averager_core #(
    .BUF_DEPTH (BUF_DEPTH),
    .SENSORS   (SENSORS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  warmup_gated_window_averager_checker #(
    .BUF_DEPTH (BUF_DEPTH),
    .SENSORS   (SENSORS)
  ) u_avg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Receiver: long hold-off on request, else random stalls
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Reading with extra weight on the extremes
  function automatic logic [wag_pkg::VAL_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return wag_pkg::VAL_W'($urandom);
  endfunction

  function automatic logic [wag_pkg::SENS_W-1:0] rand_sensor();
    return wag_pkg::SENS_W'($urandom_range(0, wag_pkg::NUM_IDX - 1));
  endfunction

  // Offer one input beat and hold it until accepted; entered at a falling edge
  task automatic drive_beat(input wag_pkg::cmd_t cmd,
                            input logic [wag_pkg::SENS_W-1:0] s,
                            input logic [wag_pkg::VAL_W-1:0] v1,
                            input logic [wag_pkg::VAL_W-1:0] v2,
                            input logic [wag_pkg::VAL_W-1:0] v3);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.command      <= cmd;
    in_bus.sensor_index <= s;
    in_bus.pm1_value    <= v1;
    in_bus.pm25_value   <= v2;
    in_bus.pm10_value   <= v3;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input wag_pkg::cmd_t cmd, input logic [wag_pkg::SENS_W-1:0] s);
    drive_beat(cmd, s, rand_value(), rand_value(), rand_value());
  endtask

  // APB write of warm_up_seconds; entered at a falling edge
  task automatic write_warm_up(input logic [wag_pkg::WARM_W-1:0] secs);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WARM_UP_ADDR;
    pwdata  <= wag_pkg::CFG_DW'(secs);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    warm_now = secs;
  endtask

  // Let all requested averages come back, then let the block settle
  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One measurement run: mostly a start, ticks, then samples with averages; sometimes noise
  task automatic run_sequence(input bit first_in_phase);
    int n_lead;
    int n_body;
    int pick;
    // Noise: any command in any order
    if (!first_in_phase && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(4, 12)) begin
        send_random(wag_pkg::cmd_t'($urandom_range(0, 3)), rand_sensor());
      end
      return;
    end
    if (warm_now == 1) begin
      // Cross the one-second threshold once per phase
      if (first_in_phase) begin
        send_random(wag_pkg::CMD_START, rand_sensor());
        n_lead = $urandom_range(990, 1000);
      end else begin
        n_lead = $urandom_range(0, 2);
      end
    end else begin
      if ($urandom_range(0, 4) != 0) send_random(wag_pkg::CMD_START, rand_sensor());
      n_lead = $urandom_range(0, 3);
    end
    repeat (n_lead) send_random(wag_pkg::CMD_TICK, rand_sensor());
    // Mostly short fills, sometimes enough to wrap the ring
    n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80) : $urandom_range(0, 40);
    repeat (n_body) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_random(wag_pkg::CMD_SAMPLE, rand_sensor());
      else if (pick < 88) send_random(wag_pkg::CMD_TICK, rand_sensor());
      else send_random(wag_pkg::CMD_AVERAGE, rand_sensor());
    end
    send_random(wag_pkg::CMD_AVERAGE, wag_pkg::SENS_W'(0));
    send_random(wag_pkg::CMD_AVERAGE, wag_pkg::SENS_W'(1));
  endtask

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_bus.valid        = 1'b0;
    in_bus.command      = wag_pkg::CMD_START;
    in_bus.sensor_index = '0;
    in_bus.pm1_value    = '0;
    in_bus.pm25_value   = '0;
    in_bus.pm10_value   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty sensors, warm-up overwrite, extremes, truncation, restart
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b1, '0, '0, '0);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b0, '1, '1, '1);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_TICK, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b0, '1, '1, '1);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b1, 16'h8000, 16'h7fff, 16'h0001);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b1, '0, '0, '0);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b0, 16'h0001, 16'h0002, 16'h0003);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_START, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b0, '0, '0, '0);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b1, '0, '0, '0);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b1, 16'h1234, 16'h5678, 16'h9abc);
    drive_beat(wag_pkg::CMD_TICK, 1'b1, '1, '1, '1);
    drive_beat(wag_pkg::CMD_SAMPLE, 1'b1, '1, '0, '1);
    drive_beat(wag_pkg::CMD_AVERAGE, 1'b1, '0, '0, '0);
    in_bus.valid <= 1'b0;
    drain();

    // Random phases, each under its own register value and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_warm_up(wag_pkg::WARM_W'(PHASE_WARM[p]));
      src_idle_pct  = PHASE_SRC[p];
      snk_stall_pct = PHASE_SNK[p];
      if (PHASE_HOLD[p]) hold_requests++;
      phase_end = beats_sent + PHASE_BEATS[p];
      run_sequence(1'b1);
      while (beats_sent < phase_end) run_sequence(1'b0);
      in_bus.valid <= 1'b0;
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/wag_pkg.sv
hw/rtl/wag_in_if.sv
hw/rtl/wag_out_if.sv
hw/rtl/wag_div.sv
hw/rtl/warmup_gated_window_averager_core.sv
dv/warmup_gated_window_averager_checker.sv
dv/warmup_gated_window_averager_core_tb.sv
